### src/ffsa_pkg.sv
// Shared types and codes for the first-fit segment allocator.
package ffsa_pkg;

    localparam logic FUNC_ALLOC   = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    localparam logic [1:0] ST_PLACED    = 2'd0;
    localparam logic [1:0] ST_COMPACTED = 2'd1;
    localparam logic [1:0] ST_NO_SPACE  = 2'd2;

    typedef struct packed {
        logic       func;
        logic [7:0] owner;
        logic [5:0] size;
    } t_req;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] start_res;
        logic [5:0] count;
        logic [5:0] free_after;
    } t_resp;

endpackage

### src/ffsa_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module ffsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/first_fit_segment_allocator_top.sv
// First-fit segment allocator: a row of UNITS owner tags (0 = free) held in
// a RAM with one write and one registered read port per cycle. After reset
// a clearing pass writes every unit free, during which no request is taken.
// One request is worked at a time; the RAM port pair sets the timing, since
// every step visits one unit per cycle:
//   - owner 0, or allocate of size 0 or above the free total: no RAM pass
//   - allocate in place: scan for the first fitting run, then one write per
//     unit of size
//   - allocate with compaction: full scan, compaction pass, then a tail
//     write of the owner's units and the remaining free units
//   - release: scan up to the end of the first run
// A finished result sits in an output register; a new request is taken while
// it waits, and the next result is held back until that transfer completes.
// The free total is kept in a counter, so no counting pass is needed.
module first_fit_segment_allocator_top #(
    parameter int UNITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ffsa_pkg::t_req i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output ffsa_pkg::t_resp o_out_data
);
    import ffsa_pkg::*;

    localparam int AW   = (UNITS > 1) ? $clog2(UNITS) : 1;
    localparam int CW   = $clog2(UNITS + 1);
    localparam int CMPW = (CW > 6) ? CW : 6;
    localparam int SW   = (AW > 5) ? AW : 5;

    // Sequencer states
    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_SCAN    = 3'd2;  // look for a free run
    localparam logic [2:0] S_FILL    = 3'd3;  // write owner into found run
    localparam logic [2:0] S_COMPACT = 3'd4;  // slide used units left
    localparam logic [2:0] S_TAIL    = 3'd5;  // owner, then free, to the end
    localparam logic [2:0] S_REL     = 3'd6;  // free first run of owner
    localparam logic [2:0] S_DONE    = 3'd7;  // hand result to output reg

    localparam logic [CW-1:0] LAST_POS  = CW'(UNITS - 1);
    localparam logic [CW-1:0] ALL_UNITS = CW'(UNITS);

    logic [2:0]      r_state,     n_state;
    logic            r_func,      n_func;
    logic [7:0]      r_owner,     n_owner;
    logic [5:0]      r_left,      n_left;
    logic [CMPW-1:0] r_cnt,       n_cnt;
    logic [AW-1:0]   r_start,     n_start;
    logic            r_started,   n_started;
    logic [1:0]      r_status,    n_status;
    logic [CW-1:0]   r_iss,       n_iss;
    logic [CW-1:0]   r_pos,       n_pos;
    logic            r_pend,      n_pend;
    logic [CW-1:0]   r_run_len,   n_run_len;
    logic [AW-1:0]   r_run_base,  n_run_base;
    logic [CW-1:0]   r_wp,        n_wp;
    logic [CW-1:0]   r_free,      n_free;
    logic            r_out_valid, n_out_valid;
    t_resp           r_out,       n_out;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [7:0]      ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [7:0]      rd_data;

    logic            streaming;
    logic            issue;
    logic            last_pos;
    logic [CW-1:0]   run_len_inc;
    logic [CMPW-1:0] free_calc;
    logic [SW-1:0]   start_ext;

    ffsa_ram #(
        .WIDTH (8),
        .DEPTH (UNITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd_data)
    );

    // Read stream: one address per cycle, data arriving in the next cycle at r_pos.
    assign streaming   = (r_state == S_SCAN) || (r_state == S_COMPACT) ||
                         (r_state == S_REL);
    assign issue       = streaming && (r_iss != ALL_UNITS);
    assign ram_raddr   = r_iss[AW-1:0];
    assign last_pos    = (r_pos == LAST_POS);
    assign run_len_inc = r_run_len + CW'(1);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_owner     = r_owner;
        n_left      = r_left;
        n_cnt       = r_cnt;
        n_start     = r_start;
        n_started   = r_started;
        n_status    = r_status;
        n_iss       = issue ? (r_iss + CW'(1)) : r_iss;
        n_pos       = r_pos;
        n_pend      = issue;
        n_run_len   = r_run_len;
        n_run_base  = r_run_base;
        n_wp        = r_wp;
        n_free      = r_free;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = r_wp[AW-1:0];
        ram_wdata   = '0;
        free_calc   = '0;
        start_ext   = '0;

        // output register drains independently of the sequencer
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                if (r_wp == LAST_POS) begin
                    n_wp    = '0;
                    n_state = S_IDLE;
                end else begin
                    n_wp = r_wp + CW'(1);
                end
            end

            S_IDLE: begin
                if (i_in_valid) begin
                    n_func     = i_in_data.func;
                    n_owner    = i_in_data.owner;
                    n_left     = i_in_data.size;
                    n_cnt      = '0;
                    n_start    = '0;
                    n_started  = 1'b0;
                    n_status   = ST_PLACED;
                    n_iss      = '0;
                    n_pos      = '0;
                    n_run_len  = '0;
                    n_run_base = '0;
                    if (i_in_data.owner == 8'd0) begin
                        n_state = S_DONE;
                    end else if (i_in_data.func == FUNC_RELEASE) begin
                        n_state = S_REL;
                    end else if (i_in_data.size == 6'd0) begin
                        n_state = S_DONE;
                    end else if (CMPW'(i_in_data.size) > CMPW'(r_free)) begin
                        n_status = ST_NO_SPACE;
                        n_state  = S_DONE;
                    end else begin
                        n_cnt   = CMPW'(i_in_data.size);
                        n_state = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                if (r_pend) begin
                    n_pos = r_pos + CW'(1);
                    if (rd_data == 8'd0) begin
                        n_run_len = run_len_inc;
                        if (r_run_len == '0) begin
                            n_run_base = r_pos[AW-1:0];
                        end
                        if (CMPW'(run_len_inc) >= CMPW'(r_left)) begin
                            // first run long enough: its base is the target
                            n_start = (r_run_len == '0) ? r_pos[AW-1:0] : r_run_base;
                            n_wp    = CW'(n_start);
                            n_state = S_FILL;
                        end
                    end else begin
                        n_run_len = '0;
                    end
                    if (last_pos && (n_state == S_SCAN)) begin
                        // no fitting run: compact, then place at the tail
                        n_status = ST_COMPACTED;
                        n_iss    = '0;
                        n_pos    = '0;
                        n_pend   = 1'b0;
                        n_wp     = '0;
                        n_state  = S_COMPACT;
                    end
                end
            end

            S_FILL: begin
                ram_we    = 1'b1;
                ram_wdata = r_owner;
                n_wp      = r_wp + CW'(1);
                n_left    = r_left - 6'd1;
                if (r_left == 6'd1) begin
                    n_state = S_DONE;
                end
            end

            S_COMPACT: begin
                if (r_pend) begin
                    n_pos = r_pos + CW'(1);
                    if (rd_data != 8'd0) begin
                        // write pointer never passes the read stream
                        ram_we    = 1'b1;
                        ram_wdata = rd_data;
                        n_wp      = r_wp + CW'(1);
                    end
                    if (last_pos) begin
                        n_start = n_wp[AW-1:0];
                        n_state = S_TAIL;
                    end
                end
            end

            S_TAIL: begin
                ram_we = 1'b1;
                if (r_left != 6'd0) begin
                    ram_wdata = r_owner;
                    n_left    = r_left - 6'd1;
                end
                if (r_wp == LAST_POS) begin
                    n_state = S_DONE;
                end else begin
                    n_wp = r_wp + CW'(1);
                end
            end

            S_REL: begin
                if (r_pend) begin
                    n_pos     = r_pos + CW'(1);
                    ram_waddr = r_pos[AW-1:0];
                    if (rd_data == r_owner) begin
                        ram_we = 1'b1;
                        n_cnt  = r_cnt + CMPW'(1);
                        if (!r_started) begin
                            n_start   = r_pos[AW-1:0];
                            n_started = 1'b1;
                        end
                        if (last_pos) begin
                            n_state = S_DONE;
                        end
                    end else if (r_started || last_pos) begin
                        n_state = S_DONE;
                    end
                end
            end

            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    if (r_func == FUNC_RELEASE) begin
                        free_calc = CMPW'(r_free) + r_cnt;
                    end else begin
                        free_calc = CMPW'(r_free) - r_cnt;
                    end
                    start_ext        = SW'(r_start);
                    n_free           = free_calc[CW-1:0];
                    n_out.status     = r_status;
                    n_out.start_res  = start_ext[4:0];
                    n_out.count      = r_cnt[5:0];
                    n_out.free_after = free_calc[5:0];
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_iss       <= '0;
            r_pos       <= '0;
            r_pend      <= 1'b0;
            r_wp        <= '0;
            r_free      <= ALL_UNITS;
            r_out_valid <= 1'b0;
            r_started   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_iss       <= n_iss;
            r_pos       <= n_pos;
            r_pend      <= n_pend;
            r_wp        <= n_wp;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
            r_started   <= n_started;
        end
    end

    // request payload and working values
    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_owner    <= n_owner;
        r_left     <= n_left;
        r_cnt      <= n_cnt;
        r_start    <= n_start;
        r_status   <= n_status;
        r_run_len  <= n_run_len;
        r_run_base <= n_run_base;
        r_out      <= n_out;
    end

endmodule
